@@ design/grib2rl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grib2rl_pkg
// Shared types, constants and the run flush function of the run-length
// level decoder.
// ----------------------------------------------------------------------------
package grib2rl_pkg;

  localparam int unsigned CNT_W    = 25;
  localparam int unsigned IDX_W    = 24;
  localparam int unsigned BASE_W   = 15;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_AW     = 2;
  localparam logic [CNT_W-1:0] SAT25 = {CNT_W{1'b1}};

  typedef enum logic [CFG_AW-1:0] {
    CFG_MAX_LEVEL      = 2'd0,
    CFG_BITS_PER_VALUE = 2'd1,
    CFG_GRID_COLUMNS   = 2'd2,
    CFG_GRID_ROWS      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]       level;
    logic [CNT_W-1:0] run_length;
    logic [IDX_W-1:0] start_index;
    logic             image_done;
  } result_t;

  // results caused by one input byte
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } group_t;

  typedef struct packed {
    logic             emit;
    result_t          res;
    logic [CNT_W-1:0] pos;
    logic             full;
  } flush_t;

  // Emit the pending run, clipped to the points left in the grid.
  function automatic flush_t run_flush(input logic             pv,
                                       input logic             full,
                                       input logic [7:0]       lvl,
                                       input logic [CNT_W-1:0] acc,
                                       input logic [CNT_W-1:0] pos,
                                       input logic [CNT_W-1:0] total);
    flush_t         f;
    logic [CNT_W-1:0] remain;
    logic [CNT_W:0]   run;
    logic [CNT_W:0]   npos;
    f        = '0;
    f.pos    = pos;
    f.full   = full;
    remain   = (pos < total) ? total - pos : '0;
    run      = {1'b0, acc} + {{CNT_W{1'b0}}, 1'b1};
    if (run > {1'b0, remain}) begin
      run = {1'b0, remain};
    end
    npos = {1'b0, pos} + run;
    if (pv && !full) begin
      f.emit            = 1'b1;
      f.res.level       = lvl;
      f.res.run_length  = run[CNT_W-1:0];
      f.res.start_index = pos[IDX_W-1:0];
      f.pos             = npos[CNT_W-1:0];
      f.full            = (npos >= {1'b0, total});
      f.res.image_done  = f.full;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

@@ design/grib2_run_length_level_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grib2_run_length_level_decoder_core
// Run-length level decoder for template 5.200 packed grid bytes.
// ----------------------------------------------------------------------------
// Usage: feed packed bytes on the in_ channel (valid/stall), one transaction
// per byte, with in_first_byte on the first byte of a section and
// in_section_end on its last. Each finished run leaves on the out_ channel as
// level, run length, start index and image_done; out_last_of_item marks the
// final result caused by a byte. A byte yields zero, one or two results.
// Path: a byte taken into the input register is decoded from there, and its
// results are written into the result queue. Throughput: one byte per cycle
// while the queue is not full; a byte with two results leaves them as two
// output transactions. The result queue holds 4 byte groups.
// Reset: registers return to max_level 98, bits_per_value 8, grid
// 2560 x 3360; no run pending, position zero, queue empty.
// Stall: results wait in the queue; when it is full the input register holds
// and in_stall rises. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module grib2_run_length_level_decoder_core
  import grib2rl_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_first_byte,
  input  wire logic              in_section_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_level,
  output logic [CNT_W-1:0]       out_run_length,
  output logic [IDX_W-1:0]       out_start_index,
  output logic                   out_image_done,
  output logic                   out_last_of_item
);

  localparam int unsigned SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int unsigned TOTAL_W = $clog2(MAX_SIDE * MAX_SIDE + 1);

  // configuration
  logic [7:0]       max_level_r;
  logic [3:0]       bpv_r;
  logic [CFG_W-1:0] cols_r, rows_r;
  logic [SIDE_W-1:0] cols_c, rows_c;
  logic [TOTAL_W-1:0] total_prod;
  logic [CNT_W-1:0] total_r;
  logic [15:0]      top_val;
  logic [BASE_W-1:0] base_r;

  // input register
  logic             in_vld_r, in_vld_nxt;
  logic [7:0]       byte_r;
  logic             first_r, last_r;
  logic             proc, q_full, accept;

  // decode state
  logic             pv_r, pv_nxt;
  logic [7:0]       lvl_r, lvl_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             full_r, full_nxt;

  logic [CNT_W-1:0] acc_eff, w_eff;
  logic [7:0]       digit;
  logic [CNT_W+7:0] add_prod;
  logic [CNT_W+8:0] acc_sum;
  logic [CNT_W+BASE_W-1:0] w_prod;
  logic [CNT_W-1:0] acc_sat, w_sat;
  flush_t           f1, f2;
  group_t           grp;
  logic             push;
  result_t          q_res;

  // clamp grid sides to 1..MAX_SIDE
  always_comb begin
    if (cols_r == '0) begin
      cols_c = SIDE_W'(1);
    end else if (cols_r > CFG_W'(MAX_SIDE)) begin
      cols_c = SIDE_W'(MAX_SIDE);
    end else begin
      cols_c = SIDE_W'(cols_r);
    end
    if (rows_r == '0) begin
      rows_c = SIDE_W'(1);
    end else if (rows_r > CFG_W'(MAX_SIDE)) begin
      rows_c = SIDE_W'(MAX_SIDE);
    end else begin
      rows_c = SIDE_W'(rows_r);
    end
  end

  assign total_prod = TOTAL_W'(cols_c) * TOTAL_W'(rows_c);
  assign top_val    = (16'd1 << bpv_r) - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r <= 8'd98;
      bpv_r       <= 4'd8;
      cols_r      <= CFG_W'(2560);
      rows_r      <= CFG_W'(3360);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LEVEL:      max_level_r <= cfg_wdata[7:0];
        CFG_BITS_PER_VALUE: bpv_r       <= cfg_wdata[3:0];
        CFG_GRID_COLUMNS:   cols_r      <= cfg_wdata;
        CFG_GRID_ROWS:      rows_r      <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // derived constants, registered from the configuration, settle in the cycle after a write
  always_ff @(posedge clk) begin
    total_r <= CNT_W'(total_prod);
    base_r  <= (top_val > {8'd0, max_level_r}) ?
               BASE_W'(top_val - {8'd0, max_level_r}) : '0;
  end

  // input register
  assign proc     = in_vld_r && !q_full;
  assign in_stall = in_vld_r && !proc;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_data_byte;
      first_r <= in_first_byte;
      last_r  <= in_section_end;
    end
  end

  // digit accumulation, from the state as a first byte leaves it
  assign acc_eff  = first_r ? '0 : acc_r;
  assign w_eff    = first_r ? CNT_W'(1) : w_r;
  assign digit    = byte_r - max_level_r - 8'd1;
  assign add_prod = w_eff * digit;
  assign acc_sum  = {9'd0, acc_eff} + {1'b0, add_prod};
  assign w_prod   = w_eff * base_r;
  assign acc_sat  = (acc_sum > (CNT_W+9)'(SAT25)) ? SAT25 : acc_sum[CNT_W-1:0];
  assign w_sat    = (w_prod > (CNT_W+BASE_W)'(SAT25)) ? SAT25 : w_prod[CNT_W-1:0];

  always_comb begin
    pv_nxt   = pv_r;
    lvl_nxt  = lvl_r;
    acc_nxt  = acc_eff;
    w_nxt    = w_eff;
    pos_nxt  = pos_r;
    full_nxt = full_r;
    f1       = '0;
    f2       = '0;
    if (first_r) begin
      pv_nxt   = 1'b0;
      lvl_nxt  = '0;
      pos_nxt  = '0;
      full_nxt = 1'b0;
    end
    if (!full_nxt) begin
      if (byte_r <= max_level_r) begin
        f1       = run_flush(pv_nxt, full_nxt, lvl_nxt, acc_nxt, pos_nxt, total_r);
        pos_nxt  = f1.pos;
        full_nxt = f1.full;
        pv_nxt   = 1'b0;
        if (!full_nxt) begin
          pv_nxt  = 1'b1;
          lvl_nxt = byte_r;
          acc_nxt = '0;
          w_nxt   = CNT_W'(1);
        end
      end else if (pv_nxt) begin
        acc_nxt = acc_sat;
        w_nxt   = w_sat;
      end
      if (last_r) begin
        f2       = run_flush(pv_nxt, full_nxt, lvl_nxt, acc_nxt, pos_nxt, total_r);
        pos_nxt  = f2.pos;
        full_nxt = f2.full;
        pv_nxt   = 1'b0;
      end
    end
  end

  always_comb begin
    grp.two  = f1.emit && f2.emit;
    grp.res0 = f1.emit ? f1.res : f2.res;
    grp.res1 = f2.res;
    push     = proc && (f1.emit || f2.emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      lvl_r  <= '0;
      acc_r  <= '0;
      w_r    <= CNT_W'(1);
      pos_r  <= '0;
      full_r <= 1'b0;
    end else if (proc) begin
      pv_r   <= pv_nxt;
      lvl_r  <= lvl_nxt;
      acc_r  <= acc_nxt;
      w_r    <= w_nxt;
      pos_r  <= pos_nxt;
      full_r <= full_nxt;
    end
  end

  grib2rl_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (grp),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (q_res),
    .out_last  (out_last_of_item)
  );

  assign out_level       = q_res.level;
  assign out_run_length  = q_res.run_length;
  assign out_start_index = q_res.start_index;
  assign out_image_done  = q_res.image_done;

endmodule
`default_nettype wire

@@ design/grib2rl_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grib2rl_out_queue
// Queue of result groups; hands out one or two results per group, one
// transaction per cycle while out_stall is low, marking the last result of each group.
// ----------------------------------------------------------------------------
module grib2rl_out_queue
  import grib2rl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire group_t  push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res,
  output logic         out_last
);

  group_t          grp_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            sub_r, sub_nxt;
  group_t          head;
  logic            pop_beat, pop_grp;

  assign head      = grp_r[rd_ptr_r];
  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_res   = sub_r ? head.res1 : head.res0;
  assign out_last  = head.two ? sub_r : 1'b1;
  assign pop_beat  = out_valid && !out_stall;
  assign pop_grp   = pop_beat && out_last;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_grp ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop_grp);
    sub_nxt    = pop_beat ? !out_last : sub_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ test/tb_grib2_run_length_level_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grib2_run_length_level_decoder_core
// Feeds packed grid bytes through the run-length level decoder and checks
// every emitted run (level, length, start index, image_done, last_of_item)
// against a cycle-free prediction of the decode. Covers directed corner
// bytes, many register settings and random sections with idle, stall and
// a long output hold-off.
// ----------------------------------------------------------------------------
module tb_grib2_run_length_level_decoder_core
  import grib2rl_pkg::*;
();

  typedef struct packed {
    result_t res;
    logic    last;
  } run_rec_t;

  class level_run_scoreboard;
    run_rec_t        expected_runs[$];
    int unsigned     errors;
    longint unsigned max_level;
    longint unsigned bits_per_value;
    longint unsigned grid_columns;
    longint unsigned grid_rows;
    bit              pending_valid;
    longint unsigned pending_level;
    longint unsigned run_acc;
    longint unsigned digit_weight;
    longint unsigned pixel_pos;
    bit              grid_full;

    function new();
      errors         = 0;
      max_level      = 98;
      bits_per_value = 8;
      grid_columns   = 2560;
      grid_rows      = 3360;
      clear_section();
    endfunction

    function void clear_section();
      pending_valid = 1'b0;
      pending_level = 0;
      run_acc       = 0;
      digit_weight  = 1;
      pixel_pos     = 0;
      grid_full     = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_MAX_LEVEL:      max_level      = value[7:0];
        CFG_BITS_PER_VALUE: bits_per_value = value[3:0];
        CFG_GRID_COLUMNS:   grid_columns   = value;
        CFG_GRID_ROWS:      grid_rows      = value;
        default: ;
      endcase
    endfunction

    function longint unsigned side_of(longint unsigned v);
      if (v < 1) return 1;
      if (v > 4096) return 4096;
      return v;
    endfunction

    // Close the pending run, clipped to the points left in the grid.
    function bit close_run(output run_rec_t r);
      longint unsigned total;
      longint unsigned remain;
      longint unsigned run;
      r = '0;
      if (!pending_valid || grid_full) begin
        pending_valid = 1'b0;
        return 1'b0;
      end
      total  = side_of(grid_columns) * side_of(grid_rows);
      remain = (pixel_pos < total) ? total - pixel_pos : 0;
      run    = run_acc + 1;
      if (run > remain) begin
        run = remain;
      end
      r.res.level       = pending_level[7:0];
      r.res.run_length  = run[CNT_W-1:0];
      r.res.start_index = pixel_pos[IDX_W-1:0];
      pixel_pos         = pixel_pos + run;
      grid_full         = (pixel_pos >= total);
      r.res.image_done  = grid_full;
      pending_valid     = 1'b0;
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic first, logic sec_end);
      run_rec_t        found[$];
      run_rec_t        r;
      longint unsigned top;
      longint unsigned base;
      longint unsigned sum;
      longint unsigned w;
      if (first) begin
        clear_section();
      end
      if (grid_full) begin
        return;
      end
      if (b <= max_level) begin
        if (close_run(r)) begin
          found.push_back(r);
        end
        if (!grid_full) begin
          pending_valid = 1'b1;
          pending_level = b;
          run_acc       = 0;
          digit_weight  = 1;
        end
      end else if (pending_valid) begin
        top          = (64'd1 << bits_per_value) - 1;
        base         = (top > max_level) ? top - max_level : 0;
        sum          = run_acc + digit_weight * (b - max_level - 1);
        w            = digit_weight * base;
        run_acc      = (sum > SAT25) ? SAT25 : sum;
        digit_weight = (w > SAT25) ? SAT25 : w;
      end
      if (sec_end) begin
        if (close_run(r)) begin
          found.push_back(r);
        end
      end
      if (found.size() > 0) begin
        found[found.size()-1].last = 1'b1;
      end
      foreach (found[i]) begin
        expected_runs.push_back(found[i]);
      end
    endfunction

    function string show(run_rec_t r);
      return $sformatf("level %0d run %0d start %0d done %0b last %0b", r.res.level,
                       r.res.run_length, r.res.start_index, r.res.image_done, r.last);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR @%0t: %s", $time, msg);
      end
    endfunction

    function void check_run(run_rec_t act);
      run_rec_t exp_run;
      if (expected_runs.size() == 0) begin
        flag($sformatf("unexpected run: %s", show(act)));
        return;
      end
      exp_run = expected_runs.pop_front();
      if (act.res.level !== exp_run.res.level ||
          act.res.run_length !== exp_run.res.run_length ||
          act.res.start_index !== exp_run.res.start_index ||
          act.res.image_done !== exp_run.res.image_done ||
          act.last !== exp_run.last) begin
        flag($sformatf("run mismatch: expected %s, got %s", show(exp_run), show(act)));
      end
    endfunction

    function int unsigned outstanding();
      return expected_runs.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_data_byte;
  logic              in_first_byte;
  logic              in_section_end;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_level;
  logic [CNT_W-1:0]  out_run_length;
  logic [IDX_W-1:0]  out_start_index;
  logic              out_image_done;
  logic              out_last_of_item;

  level_run_scoreboard sb;
  bit                  idle_en;
  bit                  pressure_go;
  int unsigned         items_sent;

  grib2_run_length_level_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_section_end   (in_section_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level        (out_level),
    .out_run_length   (out_run_length),
    .out_start_index  (out_start_index),
    .out_image_done   (out_image_done),
    .out_last_of_item (out_last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Note accepted bytes first, then check results of the same edge.
  always @(posedge clk) begin
    run_rec_t act;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_byte(in_data_byte, in_first_byte, in_section_end);
      end
      if (out_valid && !out_stall) begin
        act.res.level       = out_level;
        act.res.run_length  = out_run_length;
        act.res.start_index = out_start_index;
        act.res.image_done  = out_image_done;
        act.last            = out_last_of_item;
        sb.check_run(act);
      end
    end
  end

  // Output side: random stall, plus one long hold-off to back the block up.
  initial begin
    int unsigned hold_left;
    bit          pressure_used;
    hold_left     = 0;
    pressure_used = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_used) begin
        pressure_used = 1'b1;
        hold_left     = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 15);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic sec_end);
    if (idle_en && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_first_byte  <= first;
    in_section_end <= sec_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected run has left the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] ml, input logic [3:0] bpv,
                               input logic [12:0] cols, input logic [12:0] rows);
    put_reg(CFG_MAX_LEVEL, CFG_W'(ml));
    put_reg(CFG_BITS_PER_VALUE, CFG_W'(bpv));
    put_reg(CFG_GRID_COLUMNS, cols);
    put_reg(CFG_GRID_ROWS, rows);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_level();
    return 8'($urandom_range(32'(sb.max_level), 0));
  endfunction

  // Mostly digits inside the packing range, sometimes any byte above the level.
  function automatic logic [7:0] pick_digit();
    longint unsigned top;
    top = (64'd1 << sb.bits_per_value) - 1;
    if (top > 255) begin
      top = 255;
    end
    if (top > sb.max_level && $urandom_range(99) < 85) begin
      return 8'($urandom_range(32'(top), 32'(sb.max_level + 1)));
    end
    return 8'($urandom_range(255, 32'(sb.max_level + 1)));
  endfunction

  task automatic send_section();
    logic [7:0] bytes[$];
    int unsigned nruns;
    int unsigned ndig;
    bit          keep_first;
    bit          keep_end;
    keep_first = ($urandom_range(99) < 92);
    keep_end   = ($urandom_range(99) < 92);
    if ($urandom_range(99) < 5) begin
      bytes.push_back(pick_digit());
    end
    nruns = $urandom_range(6, 1);
    for (int r = 0; r < nruns; r++) begin
      bytes.push_back(pick_level());
      ndig = ($urandom_range(99) < 10) ? $urandom_range(9, 4) : $urandom_range(3, 0);
      for (int d = 0; d < ndig; d++) begin
        bytes.push_back(pick_digit());
      end
    end
    foreach (bytes[i]) begin
      send_byte(bytes[i], (i == 0) && keep_first, (i == bytes.size() - 1) && keep_end);
    end
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        send_section();
      end else begin
        send_byte(8'($urandom_range(255, 0)), $urandom_range(99) < 10,
                  $urandom_range(99) < 20);
      end
    end
    drain();
  endtask

  initial begin
    sb             = new();
    idle_en        = 1'b1;
    pressure_go    = 1'b0;
    items_sent     = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_MAX_LEVEL;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_data_byte   <= '0;
    in_first_byte  <= 1'b0;
    in_section_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: saturating count, clip at the full grid, then ignore.
    send_byte(8'd0, 1'b1, 1'b0);
    repeat (5) send_byte(8'd255, 1'b0, 1'b0);
    send_byte(8'd99, 1'b0, 1'b0);
    send_byte(8'd98, 1'b0, 1'b0);
    send_byte(8'd200, 1'b0, 1'b0);
    send_byte(8'd10, 1'b0, 1'b1);
    // Digit with no level, level with section end, two runs from one byte.
    send_byte(8'd200, 1'b1, 1'b0);
    send_byte(8'd98, 1'b0, 1'b1);
    send_byte(8'd5, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b1);
    // Drop the pending run on a new section.
    send_byte(8'd7, 1'b1, 1'b0);
    send_byte(8'd150, 1'b0, 1'b0);
    send_byte(8'd3, 1'b1, 1'b0);
    send_byte(8'd255, 1'b0, 1'b1);
    drain();

    // Zero digit base and grid sides outside the legal range.
    load_settings(8'd200, 4'd4, 13'd0, 13'd8191);
    send_byte(8'd10, 1'b1, 1'b0);
    send_byte(8'd201, 1'b0, 1'b0);
    send_byte(8'd255, 1'b0, 1'b0);
    send_byte(8'd255, 1'b0, 1'b0);
    send_byte(8'd20, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: load_settings(8'd0, 4'd1, 13'd1, 13'd1);
        1: load_settings(8'd254, 4'd8, 13'd4096, 13'd4096);
        2: load_settings(8'd254, 4'd4, 13'd3, 13'd5);
        3: load_settings(8'd98, 4'd8, 13'd2560, 13'd3360);
        4: load_settings(8'($urandom_range(254, 0)), 4'd0, 13'd8191, 13'd0);
        5: load_settings(8'($urandom_range(254, 0)), 4'd15, 13'($urandom_range(60, 1)),
                         13'($urandom_range(60, 1)));
        default: load_settings(8'($urandom_range(254, 0)), 4'($urandom_range(8, 1)),
                               13'($urandom_range(40, 1)), 13'($urandom_range(40, 1)));
      endcase
      // Phases 3 and 4 run without idling; phase 3 also holds the output off.
      idle_en = !(p == 3 || p == 4);
      if (p == 3) begin
        pressure_go = 1'b1;
      end
      run_phase(68);
    end
    idle_en = 1'b1;

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
